>>> rtl/i2cmts_pkg.sv
// i2cmts_pkg: constants, codes and types shared by the i2c transaction sequencer
// depends on nothing; used by i2c_master_transaction_sequencer_unit and its testbench
package i2cmts_pkg;

  // depth of the write and read data buffers
  localparam int MAX_BYTES = 16;
  localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  // item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_REQ   = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;
  localparam logic [1:0] FUNC_READB = 2'd3;

  // operation codes
  localparam logic [1:0] OP_PING    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  // status codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BUSY  = 3'd1;
  localparam logic [2:0] ST_OK    = 3'd2;
  localparam logic [2:0] ST_NAK   = 3'd3;
  localparam logic [2:0] ST_STUCK = 3'd4;
  localparam logic [2:0] ST_GATE  = 3'd5;
  localparam logic [2:0] ST_BAD   = 3'd6;

  // bus action codes
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_SEND  = 3'd2;
  localparam logic [2:0] ACT_RECV  = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;

  // byte steps within a transaction
  localparam logic [1:0] STEP_ADDR = 2'd0;
  localparam logic [1:0] STEP_REG  = 2'd1;
  localparam logic [1:0] STEP_DATA = 2'd2;

  // one buffer write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } buf_wr_t;

endpackage

>>> rtl/i2c_master_transaction_sequencer_unit.sv
// i2c_master_transaction_sequencer_unit: phase-level i2c master sequencer, top level
// depends on i2cmts_pkg and i2cmts_bufs
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid_i/in_ready_o | func, dev_addr, operation, reg_addr, length,
//          |                      | data_byte, buf_index, bus_granted, slave_ack,
//          |                      | rx_byte, scl_timeout
//  out     | out_valid_o/out_ready_i | accepted, status, phase_now, bus_action,
//          |                      | tx_value, master_ack, busy_flag, release_request,
//          |                      | read_data, read_valid
//
// the phase decision for every word is made between the input ports and the result
// register, and the state is updated at the same edge
// one result word per input word; a new word is taken in every cycle in which the
// result register is empty or being emptied
// a stalled output holds the result and the input side stops until it is taken
// reset clears the phase, status and control registers; buffers are not cleared
module i2c_master_transaction_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [6:0] dev_addr_i,
  input  logic [1:0] operation_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] length_i,
  input  logic [7:0] data_byte_i,
  input  logic [3:0] buf_index_i,
  input  logic       bus_granted_i,
  input  logic       slave_ack_i,
  input  logic [7:0] rx_byte_i,
  input  logic       scl_timeout_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       accepted_o,
  output logic [2:0] status_o,
  output logic [2:0] phase_now_o,
  output logic [2:0] bus_action_o,
  output logic [7:0] tx_value_o,
  output logic       master_ack_o,
  output logic       busy_flag_o,
  output logic       release_request_o,
  output logic [7:0] read_data_o,
  output logic       read_valid_o
);

  localparam int IDX_W = i2cmts_pkg::IDX_W;
  localparam int CNT_W = i2cmts_pkg::CNT_W;

  // phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_OPEN    = 3'd1;
  localparam logic [2:0] PH_SEND    = 3'd2;
  localparam logic [2:0] PH_REOPEN  = 3'd3;
  localparam logic [2:0] PH_RECV    = 3'd4;
  localparam logic [2:0] PH_STOP    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  // state
  logic [2:0]       phase_q, phase_d;
  logic [1:0]       step_q, step_d;
  logic [6:0]       target_q, target_d;
  logic [1:0]       op_q, op_d;
  logic [7:0]       regb_q, regb_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] index_q, index_d;
  logic [7:0]       shift_q, shift_d;
  logic             rd_pend_q, rd_pend_d;
  logic [2:0]       status_q, status_d;
  logic             flight_q, flight_d;
  logic             rel_q, rel_d;

  // result register
  logic       out_valid_q;
  logic       acc_q, acc_d;
  logic [2:0] act_q, act_d;
  logic [7:0] txv_q, txv_d;
  logic       mack_q, mack_d;
  logic       rvalid_q, rvalid_d;

  logic             in_fire;
  logic             active;
  logic [CNT_W-1:0] index_inc;
  logic [CNT_W-1:0] wbuf_sel;
  logic [CNT_W-1:0] wbuf_sel_nxt;
  logic [CNT_W-1:0] bidx_ext;
  logic [7:0]       wbuf_rdata;
  logic [7:0]       rbuf_rdata;
  logic [7:0]       wbuf_at;
  logic             rbuf_re;

  i2cmts_pkg::buf_wr_t wbuf_wr, rbuf_wr;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign active     = (phase_q != PH_IDLE) && (phase_q != PH_DONE);
  assign index_inc  = index_q + CNT_W'(1);
  assign bidx_ext   = CNT_W'(buf_index_i);

  // next write byte: the first after the register byte, else the one after this
  // the buffer read is registered, so it is addressed from the next state
  assign wbuf_sel     = (step_q == i2cmts_pkg::STEP_REG) ? '0 : index_inc;
  assign wbuf_sel_nxt = (step_d == i2cmts_pkg::STEP_REG) ? '0 : index_d + CNT_W'(1);
  assign wbuf_at      = (32'(wbuf_sel) < i2cmts_pkg::MAX_BYTES) ? wbuf_rdata : 8'h00;
  assign rbuf_re      = in_fire && (func_i == i2cmts_pkg::FUNC_READB);

  i2cmts_bufs #(
    .WIDTH(8),
    .DEPTH(i2cmts_pkg::MAX_BYTES)
  ) u_wbuf (
    .clk_i  (clk_i),
    .we_i   (wbuf_wr.en),
    .waddr_i(wbuf_wr.idx),
    .wdata_i(wbuf_wr.data),
    .re_i   (in_fire),
    .raddr_i(wbuf_sel_nxt[IDX_W-1:0]),
    .rdata_o(wbuf_rdata)
  );

  i2cmts_bufs #(
    .WIDTH(8),
    .DEPTH(i2cmts_pkg::MAX_BYTES)
  ) u_rbuf (
    .clk_i  (clk_i),
    .we_i   (rbuf_wr.en),
    .waddr_i(rbuf_wr.idx),
    .wdata_i(rbuf_wr.data),
    .re_i   (rbuf_re),
    .raddr_i(IDX_W'(buf_index_i)),
    .rdata_o(rbuf_rdata)
  );

  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    target_d  = target_q;
    op_d      = op_q;
    regb_d    = regb_q;
    count_d   = count_q;
    index_d   = index_q;
    shift_d   = shift_q;
    rd_pend_d = rd_pend_q;
    status_d  = status_q;
    flight_d  = flight_q;
    rel_d     = rel_q;
    acc_d     = 1'b0;
    act_d     = i2cmts_pkg::ACT_NONE;
    txv_d     = 8'h00;
    mack_d    = 1'b0;
    rvalid_d  = 1'b0;
    wbuf_wr   = '{en: 1'b0, idx: IDX_W'(buf_index_i), data: data_byte_i};
    rbuf_wr   = '{en: 1'b0, idx: index_q[IDX_W-1:0], data: rx_byte_i};

    case (func_i)
      i2cmts_pkg::FUNC_REQ: begin
        if (!active) begin
          if (!bus_granted_i) begin
            status_d = i2cmts_pkg::ST_GATE;
            phase_d  = PH_DONE;
          end else if (operation_i == i2cmts_pkg::OP_INVALID ||
                       32'(length_i) > i2cmts_pkg::MAX_BYTES) begin
            status_d = i2cmts_pkg::ST_BAD;
            phase_d  = PH_DONE;
          end else begin
            target_d  = dev_addr_i;
            op_d      = operation_i;
            regb_d    = reg_addr_i;
            count_d   = length_i[CNT_W-1:0];
            index_d   = '0;
            step_d    = i2cmts_pkg::STEP_ADDR;
            rd_pend_d = 1'b0;
            shift_d   = 8'h00;
            rel_d     = 1'b0;
            status_d  = i2cmts_pkg::ST_BUSY;
            flight_d  = 1'b1;
            phase_d   = PH_OPEN;
            acc_d     = 1'b1;
          end
        end
      end
      i2cmts_pkg::FUNC_LOAD: begin
        wbuf_wr.en = !active && (32'(buf_index_i) < i2cmts_pkg::MAX_BYTES);
      end
      i2cmts_pkg::FUNC_READB: begin
        if (status_q == i2cmts_pkg::ST_OK && bidx_ext < count_q &&
            32'(buf_index_i) < i2cmts_pkg::MAX_BYTES) begin
          rvalid_d = 1'b1;
        end
      end
      default: begin
        if (active) begin
          unique case (phase_q)
            PH_OPEN: begin
              act_d     = i2cmts_pkg::ACT_START;
              step_d    = i2cmts_pkg::STEP_ADDR;
              shift_d   = {target_q, 1'b0};
              rd_pend_d = 1'b0;
              phase_d   = PH_SEND;
            end
            PH_REOPEN: begin
              act_d     = i2cmts_pkg::ACT_START;
              step_d    = i2cmts_pkg::STEP_DATA;
              shift_d   = {target_q, 1'b1};
              rd_pend_d = 1'b1;
              phase_d   = PH_SEND;
            end
            PH_SEND: begin
              act_d = i2cmts_pkg::ACT_SEND;
              txv_d = shift_q;
              if (scl_timeout_i) begin
                status_d = i2cmts_pkg::ST_STUCK;
                phase_d  = PH_STOP;
              end else if (!slave_ack_i) begin
                status_d = i2cmts_pkg::ST_NAK;
                phase_d  = PH_STOP;
              end else if (op_q == i2cmts_pkg::OP_PING) begin
                phase_d = PH_STOP;
              end else if (step_q == i2cmts_pkg::STEP_ADDR) begin
                step_d  = i2cmts_pkg::STEP_REG;
                shift_d = regb_q;
                phase_d = PH_SEND;
              end else if (step_q == i2cmts_pkg::STEP_REG) begin
                if (op_q != i2cmts_pkg::OP_WRITE) begin
                  phase_d = PH_REOPEN;
                end else if (count_q == '0) begin
                  phase_d = PH_STOP;
                end else begin
                  step_d  = i2cmts_pkg::STEP_DATA;
                  index_d = '0;
                  shift_d = wbuf_at;
                  phase_d = PH_SEND;
                end
              end else if (rd_pend_q) begin
                // slave address with read bit went out, data follows
                rd_pend_d = 1'b0;
                phase_d   = PH_RECV;
              end else begin
                index_d = index_inc;
                if (index_inc >= count_q) begin
                  phase_d = PH_STOP;
                end else begin
                  shift_d = wbuf_at;
                  phase_d = PH_SEND;
                end
              end
            end
            PH_RECV: begin
              act_d = i2cmts_pkg::ACT_RECV;
              if (scl_timeout_i) begin
                status_d = i2cmts_pkg::ST_STUCK;
                phase_d  = PH_STOP;
              end else begin
                rbuf_wr.en = 32'(index_q) < i2cmts_pkg::MAX_BYTES;
                // ack all but the last byte
                if (index_inc < count_q) begin
                  mack_d  = 1'b1;
                  index_d = index_inc;
                  phase_d = PH_RECV;
                end else begin
                  phase_d = PH_STOP;
                end
              end
            end
            PH_STOP: begin
              act_d = i2cmts_pkg::ACT_STOP;
              if (status_q == i2cmts_pkg::ST_BUSY) begin
                status_d = i2cmts_pkg::ST_OK;
              end
              flight_d = 1'b0;
              rel_d    = 1'b1;
              phase_d  = PH_DONE;
            end
            default: begin
              // unused phase code ends like a stop without touching the status
              flight_d = 1'b0;
              rel_d    = 1'b1;
              phase_d  = PH_DONE;
            end
          endcase
        end
      end
    endcase

    if (!in_fire) begin
      wbuf_wr.en = 1'b0;
      rbuf_wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      step_q      <= i2cmts_pkg::STEP_ADDR;
      target_q    <= '0;
      op_q        <= i2cmts_pkg::OP_PING;
      regb_q      <= '0;
      count_q     <= '0;
      index_q     <= '0;
      shift_q     <= '0;
      rd_pend_q   <= 1'b0;
      status_q    <= i2cmts_pkg::ST_IDLE;
      flight_q    <= 1'b0;
      rel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q   <= phase_d;
        step_q    <= step_d;
        target_q  <= target_d;
        op_q      <= op_d;
        regb_q    <= regb_d;
        count_q   <= count_d;
        index_q   <= index_d;
        shift_q   <= shift_d;
        rd_pend_q <= rd_pend_d;
        status_q  <= status_d;
        flight_q  <= flight_d;
        rel_q     <= rel_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word payload
  logic [2:0] res_status_q, res_phase_q;
  logic       res_busy_q, res_rel_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      acc_q        <= acc_d;
      act_q        <= act_d;
      txv_q        <= txv_d;
      mack_q       <= mack_d;
      rvalid_q     <= rvalid_d;
      res_status_q <= status_d;
      res_phase_q  <= phase_d;
      res_busy_q   <= flight_d;
      res_rel_q    <= rel_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = acc_q;
  assign status_o          = res_status_q;
  assign phase_now_o       = res_phase_q;
  assign bus_action_o      = act_q;
  assign tx_value_o        = txv_q;
  assign master_ack_o      = mack_q;
  assign busy_flag_o       = res_busy_q;
  assign release_request_o = res_rel_q;
  // read buffer output register only changes on a read-back word
  assign read_data_o       = rvalid_q ? rbuf_rdata : 8'h00;
  assign read_valid_o      = rvalid_q;

endmodule

>>> rtl/i2cmts_bufs.sv
// i2cmts_bufs: small ram with one write port and one registered read port
// depends on nothing; used for both byte buffers of the sequencer
module i2cmts_bufs #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> bench/i2c_master_transaction_sequencer_unit_tb.sv
// testbench for i2c_master_transaction_sequencer_unit: directed word table, then random
// transactions, every result word checked against the table's status and phase or a phase-level predictor
// depends on i2cmts_pkg and the sequencer rtl
module i2c_master_transaction_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmts_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RANDOM_WORDS = 1700;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_FROM    = 600;
  localparam int HOLD_CYCLES  = 400;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_OPEN    = 3'd1,
    PH_SEND    = 3'd2,
    PH_REOPEN  = 3'd3,
    PH_RECV    = 3'd4,
    PH_STOP    = 3'd5,
    PH_DONE    = 3'd6
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic [1:0] operation;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic [3:0] buf_index;
    logic       bus_granted;
    logic       slave_ack;
    logic [7:0] rx_byte;
    logic       scl_timeout;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] status;
    logic [2:0] phase_now;
    logic [2:0] bus_action;
    logic [7:0] tx_value;
    logic       master_ack;
    logic       busy_flag;
    logic       release_request;
    logic [7:0] read_data;
    logic       read_valid;
  } resp_t;

  // a typed row expects the given status and phase with every other field zero
  typedef struct {
    bit         typed;
    logic [2:0] st;
    phase_e     ph;
    cmd_t       c;
  } script_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] func_i;
  logic [6:0] dev_addr_i;
  logic [1:0] operation_i;
  logic [7:0] reg_addr_i;
  logic [7:0] length_i;
  logic [7:0] data_byte_i;
  logic [3:0] buf_index_i;
  logic       bus_granted_i;
  logic       slave_ack_i;
  logic [7:0] rx_byte_i;
  logic       scl_timeout_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       accepted_o;
  logic [2:0] status_o;
  logic [2:0] phase_now_o;
  logic [2:0] bus_action_o;
  logic [7:0] tx_value_o;
  logic       master_ack_o;
  logic       busy_flag_o;
  logic       release_request_o;
  logic [7:0] read_data_o;
  logic       read_valid_o;

  resp_t due_replies[$];
  int    errors = 0;
  bit    feed_done = 1'b0;
  int    cycle_count = 0;

  // predictor state
  phase_e     seq_phase = PH_IDLE;
  logic [1:0] seq_step = STEP_ADDR;
  logic [6:0] seq_target = '0;
  logic [1:0] seq_op = OP_PING;
  logic [7:0] seq_reg = '0;
  logic [4:0] seq_count = '0;
  logic [4:0] seq_index = '0;
  logic [7:0] seq_shift = '0;
  logic       seq_read_due = 1'b0;
  logic [2:0] seq_status = ST_IDLE;
  logic       seq_busy = 1'b0;
  logic       seq_release = 1'b0;
  logic [7:0] wr_data [MAX_BYTES];
  logic [7:0] rd_data [MAX_BYTES];
  bit         wr_known [MAX_BYTES];
  bit         rd_known [MAX_BYTES];

  i2c_master_transaction_sequencer_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .dev_addr_i        (dev_addr_i),
    .operation_i       (operation_i),
    .reg_addr_i        (reg_addr_i),
    .length_i          (length_i),
    .data_byte_i       (data_byte_i),
    .buf_index_i       (buf_index_i),
    .bus_granted_i     (bus_granted_i),
    .slave_ack_i       (slave_ack_i),
    .rx_byte_i         (rx_byte_i),
    .scl_timeout_i     (scl_timeout_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .accepted_o        (accepted_o),
    .status_o          (status_o),
    .phase_now_o       (phase_now_o),
    .bus_action_o      (bus_action_o),
    .tx_value_o        (tx_value_o),
    .master_ack_o      (master_ack_o),
    .busy_flag_o       (busy_flag_o),
    .release_request_o (release_request_o),
    .read_data_o       (read_data_o),
    .read_valid_o      (read_valid_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic cmd_t w(logic [1:0] f, logic [6:0] dev, logic [1:0] op,
                             logic [7:0] ra, logic [7:0] len, logic [7:0] dat,
                             logic [3:0] idx, logic gr, logic ack, logic [7:0] rx,
                             logic to);
    return '{f, dev, op, ra, len, dat, idx, gr, ack, rx, to};
  endfunction

  function automatic cmd_t tick(logic ack, logic [7:0] rx, logic to);
    return w(FUNC_TICK, 7'h00, OP_PING, 8'h00, 8'h00, 8'h00, 4'h0, 1'b0, ack, rx, to);
  endfunction

  // one word through the phase sequencer: updates the predictor state, returns the reply
  task automatic advance_sequencer(input cmd_t c, output resp_t r);
    logic active;
    r = '0;
    active = (seq_phase != PH_IDLE) && (seq_phase != PH_DONE);
    case (c.func)
      FUNC_REQ: begin
        if (!active) begin
          if (!c.bus_granted) begin
            seq_status = ST_GATE;
            seq_phase = PH_DONE;
          end else if (c.operation == OP_INVALID || c.length > MAX_BYTES) begin
            seq_status = ST_BAD;
            seq_phase = PH_DONE;
          end else begin
            seq_target = c.dev_addr;
            seq_op = c.operation;
            seq_reg = c.reg_addr;
            seq_count = 5'(c.length);
            seq_index = '0;
            seq_step = STEP_ADDR;
            seq_read_due = 1'b0;
            seq_shift = '0;
            seq_release = 1'b0;
            seq_status = ST_BUSY;
            seq_busy = 1'b1;
            seq_phase = PH_OPEN;
            r.accepted = 1'b1;
          end
        end
      end
      FUNC_LOAD: begin
        if (!active && c.buf_index < MAX_BYTES) begin
          wr_data[c.buf_index] = c.data_byte;
          wr_known[c.buf_index] = 1'b1;
        end
      end
      FUNC_READB: begin
        if (seq_status == ST_OK && c.buf_index < seq_count && c.buf_index < MAX_BYTES) begin
          r.read_valid = 1'b1;
          r.read_data = rd_data[c.buf_index];
        end
      end
      default: begin
        if (active) begin
          case (seq_phase)
            PH_OPEN, PH_REOPEN: begin
              r.bus_action = ACT_START;
              if (seq_phase == PH_REOPEN) begin
                seq_step = STEP_DATA;
                seq_shift = {seq_target, 1'b1};
                seq_read_due = 1'b1;
              end else begin
                seq_step = STEP_ADDR;
                seq_shift = {seq_target, 1'b0};
                seq_read_due = 1'b0;
              end
              seq_phase = PH_SEND;
            end
            PH_SEND: begin
              r.bus_action = ACT_SEND;
              r.tx_value = seq_shift;
              if (c.scl_timeout) begin
                seq_status = ST_STUCK;
                seq_phase = PH_STOP;
              end else if (!c.slave_ack) begin
                seq_status = ST_NAK;
                seq_phase = PH_STOP;
              end else if (seq_op == OP_PING) begin
                seq_phase = PH_STOP;
              end else if (seq_step == STEP_ADDR) begin
                seq_step = STEP_REG;
                seq_shift = seq_reg;
                seq_phase = PH_SEND;
              end else if (seq_step == STEP_REG) begin
                // a write goes on to data unless it has no data bytes, a read turns the bus round
                if (seq_op != OP_WRITE) begin
                  seq_phase = PH_REOPEN;
                end else if (seq_count == 0) begin
                  seq_phase = PH_STOP;
                end else begin
                  seq_step = STEP_DATA;
                  seq_index = '0;
                  seq_shift = wr_data[0];
                  seq_phase = PH_SEND;
                end
              end else if (seq_read_due) begin
                seq_read_due = 1'b0;
                seq_phase = PH_RECV;
              end else begin
                seq_index = seq_index + 5'd1;
                if (seq_index >= seq_count) begin
                  seq_phase = PH_STOP;
                end else begin
                  seq_shift = wr_data[seq_index];
                  seq_phase = PH_SEND;
                end
              end
            end
            PH_RECV: begin
              r.bus_action = ACT_RECV;
              if (c.scl_timeout) begin
                seq_status = ST_STUCK;
                seq_phase = PH_STOP;
              end else begin
                rd_data[seq_index] = c.rx_byte;
                rd_known[seq_index] = 1'b1;
                r.master_ack = (int'(seq_index) + 1 < int'(seq_count));
                if (r.master_ack) seq_index = seq_index + 5'd1;
                else seq_phase = PH_STOP;
              end
            end
            PH_STOP: begin
              r.bus_action = ACT_STOP;
              if (seq_status == ST_BUSY) seq_status = ST_OK;
              seq_busy = 1'b0;
              seq_release = 1'b1;
              seq_phase = PH_DONE;
            end
            default: begin
              seq_busy = 1'b0;
              seq_release = 1'b1;
              seq_phase = PH_DONE;
            end
          endcase
        end
      end
    endcase
    r.status = seq_status;
    r.phase_now = seq_phase;
    r.busy_flag = seq_busy;
    r.release_request = seq_release;
  endtask

  // mostly well-formed transactions; never sends unloaded data or reads back a byte never received
  function automatic cmd_t random_word();
    cmd_t c;
    logic active;
    int   roll;
    int   room;
    active = (seq_phase != PH_IDLE) && (seq_phase != PH_DONE);
    c.dev_addr = 7'($urandom_range(0, 127));
    c.operation = 2'($urandom_range(0, 3));
    c.reg_addr = 8'($urandom_range(0, 255));
    c.length = 8'($urandom_range(0, 255));
    c.data_byte = 8'($urandom_range(0, 255));
    c.buf_index = 4'($urandom_range(0, 15));
    c.bus_granted = 1'($urandom_range(0, 1));
    c.slave_ack = 1'($urandom_range(0, 1));
    c.rx_byte = 8'($urandom_range(0, 255));
    c.scl_timeout = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (active) begin
      c.func = (roll < 88) ? FUNC_TICK : 2'($urandom_range(1, 3));
      c.slave_ack = ($urandom_range(0, 99) < 92);
      c.scl_timeout = ($urandom_range(0, 99) < 4);
    end else if (roll < 30) begin
      c.func = FUNC_LOAD;
    end else if (roll < 50) begin
      c.func = FUNC_READB;
    end else if (roll < 90) begin
      c.func = FUNC_REQ;
      c.bus_granted = ($urandom_range(0, 99) < 94);
      if ($urandom_range(0, 99) < 94) c.operation = 2'($urandom_range(0, 2));
      roll = $urandom_range(0, 99);
      if (roll < 70) c.length = 8'($urandom_range(0, 4));
      else if (roll < 95) c.length = 8'($urandom_range(0, MAX_BYTES));
    end else begin
      c.func = FUNC_TICK;
    end
    room = 0;
    while (room < MAX_BYTES && wr_known[room]) room++;
    if (c.func == FUNC_REQ && !active && c.bus_granted && c.operation == OP_WRITE &&
        c.length <= MAX_BYTES && c.length > room) begin
      c.length = 8'(room);
    end
    if (c.func == FUNC_READB && seq_status == ST_OK && c.buf_index < seq_count &&
        !rd_known[c.buf_index]) begin
      if (seq_count < MAX_BYTES) c.buf_index = 4'(seq_count);
      else c.func = FUNC_TICK;
    end
    return c;
  endfunction

  function automatic string show(resp_t r);
    return $sformatf({"acc=%0d st=%0d ph=%0d act=%0d tx=%02h mack=%0d busy=%0d ",
                      "rel=%0d rd=%02h rv=%0d"},
                     r.accepted, r.status, r.phase_now, r.bus_action, r.tx_value,
                     r.master_ack, r.busy_flag, r.release_request, r.read_data, r.read_valid);
  endfunction

  // input side: directed table first, then random words
  initial begin : feed
    script_row_t script[$];
    script_row_t row;
    cmd_t        c;
    resp_t       want;
    resp_t       model;
    int          total;
    in_valid_i <= 1'b0;
    func_i <= FUNC_TICK;
    dev_addr_i <= '0;
    operation_i <= OP_PING;
    reg_addr_i <= '0;
    length_i <= '0;
    data_byte_i <= '0;
    buf_index_i <= '0;
    bus_granted_i <= 1'b0;
    slave_ack_i <= 1'b0;
    rx_byte_i <= '0;
    scl_timeout_i <= 1'b0;

    // straight after reset, then gate and argument errors
    script.push_back('{1'b1, ST_IDLE, PH_IDLE, tick(1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b1, ST_IDLE, PH_IDLE,
      w(FUNC_READB, 7'h7f, OP_INVALID, 8'hff, 8'hff, 8'hff, 4'hf, 1'b1, 1'b1, 8'hff, 1'b1)});
    script.push_back('{1'b1, ST_GATE, PH_DONE,
      w(FUNC_REQ, 7'h7f, OP_PING, 8'hff, 8'h10, 8'h00, 4'h0, 1'b0, 1'b1, 8'h00, 1'b0)});
    script.push_back('{1'b1, ST_BAD, PH_DONE,
      w(FUNC_REQ, 7'h00, OP_INVALID, 8'h00, 8'h01, 8'h00, 4'h0, 1'b1, 1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b1, ST_BAD, PH_DONE,
      w(FUNC_REQ, 7'h12, OP_READ, 8'h34, 8'h11, 8'h00, 4'h0, 1'b1, 1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b1, ST_BAD, PH_DONE,
      w(FUNC_REQ, 7'h12, OP_WRITE, 8'h34, 8'hff, 8'h00, 4'h0, 1'b1, 1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b1, ST_BAD, PH_DONE,
      w(FUNC_LOAD, 7'h00, OP_PING, 8'h00, 8'h00, 8'hff, 4'h0, 1'b0, 1'b0, 8'h00, 1'b0)});
    // one-byte write to the top address; request and load while busy are ignored
    script.push_back('{1'b0, ST_IDLE, PH_IDLE,
      w(FUNC_REQ, 7'h7f, OP_WRITE, 8'hff, 8'h01, 8'h00, 4'h0, 1'b1, 1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE,
      w(FUNC_REQ, 7'h00, OP_READ, 8'h00, 8'h02, 8'h00, 4'h0, 1'b1, 1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE,
      w(FUNC_LOAD, 7'h00, OP_PING, 8'h00, 8'h00, 8'h33, 4'h0, 1'b0, 1'b0, 8'h00, 1'b0)});
    repeat (4) script.push_back('{1'b0, ST_IDLE, PH_IDLE, tick(1'b1, 8'h00, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE, tick(1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE, tick(1'b1, 8'h00, 1'b0)});
    // zero-length read still clocks one nacked byte in, hidden from read-back
    script.push_back('{1'b0, ST_IDLE, PH_IDLE,
      w(FUNC_REQ, 7'h00, OP_READ, 8'h00, 8'h00, 8'h00, 4'h0, 1'b1, 1'b0, 8'h00, 1'b0)});
    repeat (5) script.push_back('{1'b0, ST_IDLE, PH_IDLE, tick(1'b1, 8'h00, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE, tick(1'b0, 8'haa, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE, tick(1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE,
      w(FUNC_READB, 7'h00, OP_PING, 8'h00, 8'h00, 8'h00, 4'h0, 1'b0, 1'b0, 8'h00, 1'b0)});
    // ping answered with a nak
    script.push_back('{1'b0, ST_IDLE, PH_IDLE,
      w(FUNC_REQ, 7'h2a, OP_PING, 8'h55, 8'h00, 8'h00, 4'h0, 1'b1, 1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE, tick(1'b1, 8'h00, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE, tick(1'b0, 8'h00, 1'b0)});
    script.push_back('{1'b0, ST_IDLE, PH_IDLE, tick(1'b0, 8'h00, 1'b0)});

    total = script.size() + RANDOM_WORDS;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    for (int i = 0; i < total; i++) begin
      if (i < script.size()) begin
        row = script[i];
        c = row.c;
      end else begin
        row.typed = 1'b0;
        c = random_word();
      end
      advance_sequencer(c, model);
      if (row.typed) begin
        want = '0;
        want.status = row.st;
        want.phase_now = row.ph;
      end else begin
        want = model;
      end
      due_replies.push_back(want);
      // a stretch of words with no gaps at all
      if (i < 900 || i >= 1200) begin
        while ($urandom_range(0, 99) < 18) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b1;
      func_i <= c.func;
      dev_addr_i <= c.dev_addr;
      operation_i <= c.operation;
      reg_addr_i <= c.reg_addr;
      length_i <= c.length;
      data_byte_i <= c.data_byte;
      buf_index_i <= c.buf_index;
      bus_granted_i <= c.bus_granted;
      slave_ack_i <= c.slave_ack;
      rx_byte_i <= c.rx_byte;
      scl_timeout_i <= c.scl_timeout;
      do @(posedge clk_i); while (in_ready_o !== 1'b1);
    end
    in_valid_i <= 1'b0;
    feed_done = 1'b1;
  end

  // result side: random stalls, one long hold-off to back the block up, one quiet stretch
  initial begin : drain
    int n;
    out_ready_i <= 1'b0;
    n = 0;
    forever begin
      @(posedge clk_i);
      n++;
      if (n >= HOLD_FROM && n < HOLD_FROM + HOLD_CYCLES) out_ready_i <= 1'b0;
      else if (n >= 1600 && n < 2400) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 99) >= 18);
    end
  end

  always @(posedge clk_i) begin : watch
    resp_t got;
    resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{accepted_o, status_o, phase_now_o, bus_action_o, tx_value_o, master_ack_o,
              busy_flag_o, release_request_o, read_data_o, read_valid_o};
      if (due_replies.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, actual %s", $time, show(got));
      end else begin
        want = due_replies.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: result word mismatch\n  expected %s\n  actual   %s",
                   $time, show(want), show(got));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    wait (feed_done);
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
